FILE: hw/rtl/deque_with_membership_search_defines.svh
// Assertion macros used by the checker file of the deque block.
// Depends on nothing; include by bare file name.
`ifndef DEQUE_WITH_MEMBERSHIP_SEARCH_DEFINES_SVH
`define DEQUE_WITH_MEMBERSHIP_SEARCH_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted
`define DEQ_ASSERT_SAME(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is asserted
`define DEQ_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: hw/rtl/deq_pkg.sv
// Shared types and constants of the deque block: operation codes, result word layout.
// Used by the core, the output stage, the top level and the checker.
`timescale 1ns / 1ps
package deq_pkg;

    localparam int DATA_W         = 32;
    localparam int COUNT_W        = 5;
    localparam int OP_W           = 2;
    localparam int DEF_DEPTH      = 16;
    localparam int DEF_WORD_WIDTH = 32;

    typedef enum logic [OP_W-1:0] {
        OP_QUERY    = 2'd0,
        OP_PUSH     = 2'd1,
        OP_POP_HEAD = 2'd2,
        OP_POP_TAIL = 2'd3
    } op_t;

    // Last member sits in the lowest bits
    typedef struct packed {
        logic               push_dropped;
        logic [COUNT_W-1:0] entry_count;
        logic               match_found;
        logic               front_valid;
        logic [DATA_W-1:0]  front_word;
        logic               popped_valid;
        logic [DATA_W-1:0]  popped_word;
    } result_t;

    localparam int RES_W       = $bits(result_t);
    localparam int OUT_TDATA_W = ((RES_W + 7) / 8) * 8;

endpackage

FILE: hw/rtl/deque_with_membership_search.sv
// Deque of words in a ring of DEPTH slots with a membership search.
// An accepted word's result goes to the output register, or to the skid entry on a stall.
// Throughput: one word per cycle while the skid entry is empty; the core is combinational
// and the output register with a skid entry takes one more word while one result waits.
// Reset: rst_n clears head, tail, occupancy and the output valids; slot contents stay.
// Depends on deq_pkg, deq_core and deq_skid.
`timescale 1ns / 1ps
module deque_with_membership_search #(
    parameter int DEPTH      = deq_pkg::DEF_DEPTH,
    parameter int WORD_WIDTH = deq_pkg::DEF_WORD_WIDTH
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             s_tvalid,
    output logic                             s_tready,
    input  logic [deq_pkg::OP_W-1:0]         s_tuser,  // [1:0] operation
    input  logic [deq_pkg::DATA_W-1:0]       s_tdata,  // [31:0] data_word
    output logic                             m_tvalid,
    input  logic                             m_tready,
    // [31:0] popped_word, [32] popped_valid, [64:33] front_word, [65] front_valid,
    // [66] match_found, [71:67] entry_count, [72] push_dropped, rest zero
    output logic [deq_pkg::OUT_TDATA_W-1:0]  m_tdata
);
    import deq_pkg::*;

    logic    accept;
    result_t core_res, out_res;

    assign accept = s_tvalid && s_tready;

    deq_core #(
        .DEPTH      (DEPTH),
        .WORD_WIDTH (WORD_WIDTH)
    ) u_core (
        .clk    (clk),
        .rst_n  (rst_n),
        .accept (accept),
        .op     (op_t'(s_tuser)),
        .word   (s_tdata),
        .res    (core_res)
    );

    deq_skid u_skid (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (accept),
        .in_ready  (s_tready),
        .in_res    (core_res),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_res   (out_res)
    );

    assign m_tdata = OUT_TDATA_W'(out_res);

endmodule

FILE: hw/rtl/deq_core.sv
// Ring of word slots with head/tail pointers, occupancy and a parallel membership compare.
// Depends on deq_pkg.
`timescale 1ns / 1ps
module deq_core #(
    parameter int DEPTH      = deq_pkg::DEF_DEPTH,
    parameter int WORD_WIDTH = deq_pkg::DEF_WORD_WIDTH
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        accept,
    input  deq_pkg::op_t                op,
    input  logic [deq_pkg::DATA_W-1:0]  word,
    output deq_pkg::result_t            res
);
    import deq_pkg::*;

    localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

    logic [WORD_WIDTH-1:0] slot_reg [DEPTH];
    logic [IDX_W-1:0]      head_reg, head_next;
    logic [IDX_W-1:0]      tail_reg, tail_next;
    logic [CNT_W-1:0]      occ_reg, occ_next;

    logic [WORD_WIDTH-1:0] word_in;
    logic [IDX_W-1:0]      head_inc, tail_inc, tail_dec, pop_addr;
    logic                  full, empty, do_write, popped_ok, dropped, match;
    logic [DEPTH-1:0]      hits;

    assign word_in  = WORD_WIDTH'(word);
    assign full     = (occ_reg == FULL_CNT);
    assign empty    = (occ_reg == '0);
    assign head_inc = (head_reg == LAST_IDX) ? '0 : head_reg + 1'b1;
    assign tail_inc = (tail_reg == LAST_IDX) ? '0 : tail_reg + 1'b1;
    assign tail_dec = (tail_reg == '0) ? LAST_IDX : tail_reg - 1'b1;
    assign pop_addr = (op == OP_POP_TAIL) ? tail_dec : head_reg;

    // Slot i is held when its distance from head is below the occupancy
    always_comb
    begin
        logic [IDX_W:0] off;
        for (int i = 0; i < DEPTH; i++)
        begin
            if ((IDX_W+1)'(i) >= {1'b0, head_reg})
                off = (IDX_W+1)'(i) - {1'b0, head_reg};
            else
                off = (IDX_W+1)'(i) + (IDX_W+1)'(DEPTH) - {1'b0, head_reg};
            hits[i] = (off < (IDX_W+1)'(occ_reg)) && (slot_reg[i] == word_in);
        end
    end

    always_comb
    begin
        head_next = head_reg;
        tail_next = tail_reg;
        occ_next  = occ_reg;
        popped_ok = 1'b0;
        dropped   = 1'b0;
        match     = 1'b0;
        do_write  = 1'b0;
        case (op)
            OP_QUERY:
            begin
                match = |hits;
            end
            OP_PUSH:
            begin
                if (full)
                    dropped = 1'b1;
                else
                begin
                    do_write  = 1'b1;
                    tail_next = tail_inc;
                    occ_next  = occ_reg + 1'b1;
                end
            end
            OP_POP_HEAD:
            begin
                if (!empty)
                begin
                    popped_ok = 1'b1;
                    head_next = head_inc;
                    occ_next  = occ_reg - 1'b1;
                end
            end
            OP_POP_TAIL:
            begin
                if (!empty)
                begin
                    popped_ok = 1'b1;
                    tail_next = tail_dec;
                    occ_next  = occ_reg - 1'b1;
                end
            end
            default:
            begin
                match = 1'b0;
            end
        endcase
    end

    always_comb
    begin
        res              = '0;
        res.popped_valid = popped_ok;
        res.popped_word  = popped_ok ? DATA_W'(slot_reg[pop_addr]) : '0;
        res.front_valid  = (occ_next != '0);
        // Push onto an empty ring: the new word is the front
        if (occ_next == '0)
            res.front_word = '0;
        else if (empty)
            res.front_word = DATA_W'(word_in);
        else
            res.front_word = DATA_W'(slot_reg[head_next]);
        res.match_found  = match;
        res.entry_count  = COUNT_W'(occ_next);
        res.push_dropped = dropped;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_reg <= '0;
            tail_reg <= '0;
            occ_reg  <= '0;
        end
        else if (accept)
        begin
            head_reg <= head_next;
            tail_reg <= tail_next;
            occ_reg  <= occ_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept && do_write)
            slot_reg[tail_reg] <= word_in;
    end

endmodule

FILE: hw/rtl/deq_skid.sv
// Result register with one skid entry, so a new word is taken while a result waits.
// Depends on deq_pkg.
`timescale 1ns / 1ps
module deq_skid (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_ready,
    input  deq_pkg::result_t  in_res,
    output logic              out_valid,
    input  logic              out_ready,
    output deq_pkg::result_t  out_res
);
    import deq_pkg::*;

    result_t out_reg, skid_reg;
    logic    out_valid_reg, skid_valid_reg;
    logic    pop;

    assign in_ready  = !skid_valid_reg;
    assign out_valid = out_valid_reg;
    assign out_res   = out_reg;
    assign pop       = out_valid_reg && out_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else if (skid_valid_reg)
        begin
            // Drain the skid entry first
            if (pop)
                skid_valid_reg <= 1'b0;
        end
        else if (!out_valid_reg || pop)
            out_valid_reg <= in_valid;
        else if (in_valid)
            skid_valid_reg <= 1'b1;
    end

    always_ff @(posedge clk)
    begin
        if (skid_valid_reg)
        begin
            if (pop)
                out_reg <= skid_reg;
        end
        else if (!out_valid_reg || pop)
        begin
            if (in_valid)
                out_reg <= in_res;
        end
        else if (in_valid)
            skid_reg <= in_res;
    end

endmodule

FILE: hw/rtl/deq_checker.sv
// Port-level checks on the deque result stream, bound to the top level.
// Depends on deq_pkg and deque_with_membership_search_defines.svh.
`timescale 1ns / 1ps
`include "deque_with_membership_search_defines.svh"
module deq_checker (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             m_tvalid,
    input  logic                             m_tready,
    input  logic [deq_pkg::OUT_TDATA_W-1:0]  m_tdata
);
    import deq_pkg::*;

    result_t r;

    assign r = result_t'(m_tdata[RES_W-1:0]);

    `DEQ_ASSERT_NEXT(a_stall_hold, clk, rst_n, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata), "stalled result word changed")
    `DEQ_ASSERT_SAME(a_match_nonempty, clk, rst_n, m_tvalid && r.match_found, r.front_valid && !r.popped_valid && !r.push_dropped, "match reported on empty deque or non-query")
    `DEQ_ASSERT_SAME(a_pop_exclusive, clk, rst_n, m_tvalid && r.popped_valid, !r.push_dropped, "pop and dropped push in one result")
    `DEQ_ASSERT_SAME(a_front_zero, clk, rst_n, m_tvalid && !r.front_valid, (r.front_word == '0) && (r.entry_count == '0), "empty deque shows a front word or count")

endmodule

bind deque_with_membership_search deq_checker u_deq_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);

FILE: tb/testbench.sv
// Self-checking bench for the deque with membership search: a scoreboard class
// predicts every result word, plain tasks drive the input side, an always block the output.
// Depends on deq_pkg and the top level deque_with_membership_search.
`timescale 1ns / 1ps

class deque_scoreboard;
    logic [deq_pkg::DATA_W-1:0] slot_copy [deq_pkg::DEF_DEPTH];
    int unsigned                head_pos;
    int unsigned                tail_pos;
    int unsigned                held;
    deq_pkg::result_t           expected_q [$];
    int unsigned                error_count;

    function new();
        head_pos    = 0;
        tail_pos    = 0;
        held        = 0;
        error_count = 0;
        foreach (slot_copy[i]) slot_copy[i] = '0;
    endfunction

    function int pending();
        return expected_q.size();
    endfunction

    // Some held word, so that queries find something
    function logic [deq_pkg::DATA_W-1:0] held_word();
        if (held == 0)
            return $urandom;
        return slot_copy[(head_pos + $urandom_range(held - 1)) % deq_pkg::DEF_DEPTH];
    endfunction

    // Apply one accepted input word and queue the result it must produce
    function void note_word(deq_pkg::op_t op, logic [deq_pkg::DATA_W-1:0] word);
        deq_pkg::result_t res;
        int unsigned      pos;
        res = '0;
        case (op)
            deq_pkg::OP_QUERY:
            begin
                pos = head_pos;
                for (int unsigned k = 0; k < held; k++)
                begin
                    if (slot_copy[pos] == word)
                        res.match_found = 1'b1;
                    pos = (pos + 1) % deq_pkg::DEF_DEPTH;
                end
            end
            deq_pkg::OP_PUSH:
            begin
                if (held >= deq_pkg::DEF_DEPTH)
                begin
                    res.push_dropped = 1'b1;
                end
                else
                begin
                    slot_copy[tail_pos] = word;
                    tail_pos = (tail_pos + 1) % deq_pkg::DEF_DEPTH;
                    held++;
                end
            end
            deq_pkg::OP_POP_HEAD:
            begin
                if (held != 0)
                begin
                    res.popped_word  = slot_copy[head_pos];
                    res.popped_valid = 1'b1;
                    head_pos = (head_pos + 1) % deq_pkg::DEF_DEPTH;
                    held--;
                end
            end
            default:
            begin
                if (held != 0)
                begin
                    tail_pos = (tail_pos + deq_pkg::DEF_DEPTH - 1) % deq_pkg::DEF_DEPTH;
                    res.popped_word  = slot_copy[tail_pos];
                    res.popped_valid = 1'b1;
                    held--;
                end
            end
        endcase
        res.front_valid = (held != 0);
        res.front_word  = (held != 0) ? slot_copy[head_pos] : '0;
        res.entry_count = held[deq_pkg::COUNT_W-1:0];
        expected_q.push_back(res);
    endfunction

    task report_mismatch(string what, longint unsigned got, longint unsigned want);
        error_count++;
        $display("[%0t] MISMATCH %s: got 0x%0h, expected 0x%0h", $realtime, what, got, want);
    endtask

    task check_result(logic [deq_pkg::OUT_TDATA_W-1:0] tdata);
        deq_pkg::result_t got;
        deq_pkg::result_t want;
        got = deq_pkg::result_t'(tdata[deq_pkg::RES_W-1:0]);
        if (expected_q.size() == 0)
        begin
            report_mismatch("result word with nothing expected",
                            64'(tdata[deq_pkg::RES_W-1:0]), 64'd0);
            return;
        end
        want = expected_q.pop_front();
        if (got.popped_word != want.popped_word)
            report_mismatch("popped_word", 64'(got.popped_word), 64'(want.popped_word));
        if (got.popped_valid != want.popped_valid)
            report_mismatch("popped_valid", 64'(got.popped_valid), 64'(want.popped_valid));
        if (got.front_word != want.front_word)
            report_mismatch("front_word", 64'(got.front_word), 64'(want.front_word));
        if (got.front_valid != want.front_valid)
            report_mismatch("front_valid", 64'(got.front_valid), 64'(want.front_valid));
        if (got.match_found != want.match_found)
            report_mismatch("match_found", 64'(got.match_found), 64'(want.match_found));
        if (got.entry_count != want.entry_count)
            report_mismatch("entry_count", 64'(got.entry_count), 64'(want.entry_count));
        if (got.push_dropped != want.push_dropped)
            report_mismatch("push_dropped", 64'(got.push_dropped), 64'(want.push_dropped));
        if (tdata[deq_pkg::OUT_TDATA_W-1:deq_pkg::RES_W] != '0)
            report_mismatch("padding bits",
                            64'(tdata[deq_pkg::OUT_TDATA_W-1:deq_pkg::RES_W]), 64'd0);
    endtask
endclass

module testbench;
    import deq_pkg::*;

    localparam int STALL_LIMIT  = 1000;
    localparam int PHASE_ITEMS  = 150;

    typedef enum int {MIX_FILL, MIX_DRAIN, MIX_EVEN} op_mix_t;

    logic                    clk      = 1'b0;
    logic                    rst_n    = 1'b0;
    logic                    s_tvalid = 1'b0;
    logic                    s_tready;
    logic [OP_W-1:0]         s_tuser  = '0;
    logic [DATA_W-1:0]       s_tdata  = '0;
    logic                    m_tvalid;
    logic                    m_tready = 1'b0;
    logic [OUT_TDATA_W-1:0]  m_tdata;

    int unsigned     src_idle_pct  = 0;
    int unsigned     rcv_stall_pct = 0;
    int unsigned     quiet_cycles;
    deque_scoreboard sb;

    deque_with_membership_search u_top (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tuser  (s_tuser),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    initial
    begin
        forever #5 clk = ~clk;
    end

    // Zero, all ones, a small pool for duplicates, or anything
    function automatic logic [DATA_W-1:0] gen_word();
        int unsigned r;
        r = $urandom_range(9);
        if (r == 0)
            return '0;
        else if (r == 1)
            return '1;
        else if (r <= 4)
            return $urandom_range(7);
        return $urandom;
    endfunction

    function automatic op_t pick_op(op_mix_t mix);
        int unsigned r;
        int unsigned push_pct;
        r = $urandom_range(99);
        case (mix)
            MIX_FILL:  push_pct = 60;
            MIX_DRAIN: push_pct = 15;
            default:   push_pct = 35;
        endcase
        if (r < push_pct)
            return OP_PUSH;
        else if (r < push_pct + 20)
            return OP_QUERY;
        else if (r % 2 == 0)
            return OP_POP_HEAD;
        return OP_POP_TAIL;
    endfunction

    task automatic send_word(op_t op, logic [DATA_W-1:0] word);
        while ($urandom_range(99) < src_idle_pct)
        begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= op;
        s_tdata  <= word;
        do @(posedge clk); while (!s_tready);
        sb.note_word(op, word);
    endtask

    // Hold the sender off until every result is back
    task automatic drain_results();
        s_tvalid <= 1'b0;
        while (sb.pending() != 0) @(posedge clk);
    endtask

    task automatic run_random(int unsigned count);
        op_mix_t     mix;
        int unsigned left_in_mix;
        op_t         op;
        left_in_mix = 0;
        mix = MIX_EVEN;
        for (int unsigned n = 0; n < count; n++)
        begin
            if (left_in_mix == 0)
            begin
                case ($urandom_range(2))
                    0:       mix = MIX_FILL;
                    1:       mix = MIX_DRAIN;
                    default: mix = MIX_EVEN;
                endcase
                left_in_mix = $urandom_range(8, 40);
            end
            left_in_mix--;
            op = pick_op(mix);
            if (op == OP_QUERY && $urandom_range(1) == 1)
                send_word(op, sb.held_word());
            else
                send_word(op, gen_word());
        end
    endtask

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (m_tvalid && m_tready)
                sb.check_result(m_tdata);
            m_tready <= ($urandom_range(99) >= rcv_stall_pct);
        end
    end

    initial
    begin
        quiet_cycles = 0;
        while (quiet_cycles < STALL_LIMIT)
        begin
            @(posedge clk);
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
                quiet_cycles = 0;
            else
                quiet_cycles++;
        end
        $display("Test completed with failures");
        $finish;
    end

    initial
    begin
        sb = new();
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Empty queue: query and both pops
        send_word(OP_QUERY, '0);
        send_word(OP_POP_HEAD, '1);
        send_word(OP_POP_TAIL, '1);
        // Fill to the brim, then one push too many
        send_word(OP_PUSH, '0);
        send_word(OP_PUSH, '1);
        repeat (DEF_DEPTH - 2) send_word(OP_PUSH, gen_word());
        send_word(OP_PUSH, 32'hA5A5_5A5A);
        // Stored zero and all ones must be found, an odd value likely not
        send_word(OP_QUERY, '0);
        send_word(OP_QUERY, '1);
        send_word(OP_QUERY, 32'h1357_9BDF);
        send_word(OP_POP_TAIL, '0);
        send_word(OP_POP_HEAD, '0);
        drain_results();

        for (int phase = 0; phase < 4; phase++)
        begin
            case (phase)
                0:
                begin
                    src_idle_pct  = 0;
                    rcv_stall_pct = 0;
                end
                1:
                begin
                    src_idle_pct  = 56;
                    rcv_stall_pct = 0;
                end
                2:
                begin
                    src_idle_pct  = 0;
                    rcv_stall_pct = 56;
                end
                default:
                begin
                    src_idle_pct  = 13;
                    rcv_stall_pct = 13;
                end
            endcase
            run_random(PHASE_ITEMS);
            drain_results();
        end

        repeat (4) @(posedge clk);
        if (sb.error_count == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end
endmodule
